/* src/cpl_pkg.sv */
`timescale 1ns / 1ps
package cpl_pkg;

  localparam int CELL_W  = 6;
  localparam int DIM_W   = 7;
  localparam int IDX_W   = 12;
  localparam int SLOT_W  = 15;
  localparam int NUM_OFF = 5;
  localparam int SEL_W   = 3;

  localparam logic [DIM_W-1:0] MAX_CELLS_PER_AXIS = 7'd64;

  // half-shell offsets, first axis step is 0 or 1
  localparam logic [NUM_OFF-1:0] OFF_L = 5'b11100;
  localparam logic signed [1:0] OFF_M [NUM_OFF] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef enum logic [1:0] {
    REG_CELLS_X,
    REG_CELLS_Y,
    REG_PERIODIC_X,
    REG_PERIODIC_Y
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] cells_x;
    logic [DIM_W-1:0] cells_y;
    logic             periodic_x;
    logic             periodic_y;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  neighbour_index;
    logic signed [1:0] shift_x;
    logic signed [1:0] shift_y;
  } cand_t;

endpackage

/* src/cpl_if.sv */
`timescale 1ns / 1ps
interface cpl_in_if;
  logic                      valid;
  logic                      ready;
  logic [cpl_pkg::CELL_W-1:0] cell_x;
  logic [cpl_pkg::CELL_W-1:0] cell_y;
  logic                      new_list;

  modport source (output valid, output cell_x, output cell_y, output new_list, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input new_list, output ready);
endinterface

interface cpl_out_if;
  logic                        valid;
  logic                        ready;
  logic [cpl_pkg::IDX_W-1:0]   home_index;
  logic [cpl_pkg::IDX_W-1:0]   neighbour_index;
  logic signed [1:0]           shift_x;
  logic signed [1:0]           shift_y;
  logic [cpl_pkg::SLOT_W-1:0]  slot;
  logic                        last;

  modport source (output valid, output home_index, output neighbour_index, output shift_x,
                  output shift_y, output slot, output last, input ready);
  modport sink   (input valid, input home_index, input neighbour_index, input shift_x,
                  input shift_y, input slot, input last, output ready);
endinterface

/* src/cell_pair_list_generator.sv */
`timescale 1ns / 1ps
// path: each result beat is registered from the item register, which holds the taken input beat
// throughput: one result beat per cycle while out_ch.ready is high; a cell holds the item
//   register until its last kept pair is emitted, and a new cell can be taken as it leaves
// reset: synchronous active-low rst_n clears valid flags and the slot counter and
//   sets the grid to 1 x 1, periodic on both axes
module cell_pair_list_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  cpl_in_if.sink                     in_ch,
  cpl_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cpl_pkg::DIM_W-1:0]  cfg_data
);

  cpl_pkg::cfg_t                cfg;
  logic                         item_v_r, item_v_nxt;
  logic [cpl_pkg::CELL_W-1:0]   item_x_r;
  logic [cpl_pkg::CELL_W-1:0]   item_y_r;
  logic [cpl_pkg::NUM_OFF-1:0]  done_r, done_nxt;
  logic [cpl_pkg::SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_v_r, out_v_nxt;
  logic [cpl_pkg::IDX_W-1:0]    home_r;
  logic [cpl_pkg::IDX_W-1:0]    nbr_r;
  logic signed [1:0]            sx_r;
  logic signed [1:0]            sy_r;
  logic [cpl_pkg::SLOT_W-1:0]   slot_r;
  logic                         last_r;

  logic [cpl_pkg::IDX_W-1:0]    home_index;
  cpl_pkg::cand_t               cand [cpl_pkg::NUM_OFF];
  logic [cpl_pkg::NUM_OFF-1:0]  keep;
  logic [cpl_pkg::NUM_OFF-1:0]  rem;
  logic [cpl_pkg::NUM_OFF-1:0]  sel;
  logic [cpl_pkg::SEL_W-1:0]    pick;
  logic                         more;
  logic                         out_free;
  logic                         emit;
  logic                         item_done;
  logic                         in_ready;
  logic                         accept;

  cpl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpl_pair_calc u_calc (
    .cfg        (cfg),
    .cell_x     (item_x_r),
    .cell_y     (item_y_r),
    .home_index (home_index),
    .cand       (cand),
    .keep       (keep)
  );

  // lowest pending offset goes next
  assign rem = keep & ~done_r;
  assign sel = rem & (~rem + 5'd1);
  assign more = |(rem & ~sel);

  always_comb begin
    pick = '0;
    for (int k = cpl_pkg::NUM_OFF - 1; k >= 0; k--) begin
      if (rem[k]) pick = cpl_pkg::SEL_W'(k);
    end
  end

  assign out_free  = !out_v_r || out_ch.ready;
  assign emit      = item_v_r && (rem != '0) && out_free;
  assign item_done = item_v_r && ((rem == '0) || (emit && !more));
  assign in_ready  = !item_v_r || item_done;
  assign accept    = in_ch.valid && in_ready;

  always_comb begin
    item_v_nxt = item_v_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    out_v_nxt  = out_v_r;
    if (item_done) item_v_nxt = 1'b0;
    if (emit) begin
      done_nxt = done_r | sel;
      cnt_nxt  = cnt_r + 15'd1;
    end
    if (accept) begin
      item_v_nxt = 1'b1;
      done_nxt   = '0;
      if (in_ch.new_list) cnt_nxt = '0;
    end
    if (emit) out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      done_r   <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_x_r <= in_ch.cell_x;
      item_y_r <= in_ch.cell_y;
    end
    if (emit) begin
      home_r <= home_index;
      nbr_r  <= cand[pick].neighbour_index;
      sx_r   <= cand[pick].shift_x;
      sy_r   <= cand[pick].shift_y;
      slot_r <= cnt_r;
      last_r <= !more;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_v_r;
  assign out_ch.home_index      = home_r;
  assign out_ch.neighbour_index = nbr_r;
  assign out_ch.shift_x         = sx_r;
  assign out_ch.shift_y         = sy_r;
  assign out_ch.slot            = slot_r;
  assign out_ch.last            = last_r;

endmodule

/* src/cpl_cfg_regs.sv */
`timescale 1ns / 1ps
module cpl_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [cpl_pkg::DIM_W-1:0]   cfg_data,
  output cpl_pkg::cfg_t               cfg
);

  cpl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_x    <= 7'd1;
      cfg_r.cells_y    <= 7'd1;
      cfg_r.periodic_x <= 1'b1;
      cfg_r.periodic_y <= 1'b1;
    end else if (cfg_we) begin
      unique case (cpl_pkg::cfg_reg_t'(cfg_index))
        cpl_pkg::REG_CELLS_X:    cfg_r.cells_x    <= cfg_data;
        cpl_pkg::REG_CELLS_Y:    cfg_r.cells_y    <= cfg_data;
        cpl_pkg::REG_PERIODIC_X: cfg_r.periodic_x <= cfg_data[0];
        cpl_pkg::REG_PERIODIC_Y: cfg_r.periodic_y <= cfg_data[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/cpl_pair_calc.sv */
`timescale 1ns / 1ps
module cpl_pair_calc (
  input  cpl_pkg::cfg_t                cfg,
  input  logic [cpl_pkg::CELL_W-1:0]   cell_x,
  input  logic [cpl_pkg::CELL_W-1:0]   cell_y,
  output logic [cpl_pkg::IDX_W-1:0]    home_index,
  output cpl_pkg::cand_t               cand [cpl_pkg::NUM_OFF],
  output logic [cpl_pkg::NUM_OFF-1:0]  keep
);

  logic [cpl_pkg::DIM_W-1:0]  dx;
  logic [cpl_pkg::DIM_W-1:0]  dy;
  logic                       in_grid;
  logic                       x_last;
  logic                       y_last;
  logic                       y_first;
  logic [12:0]                prod;
  logic [cpl_pkg::IDX_W-1:0]  row_base;
  logic [cpl_pkg::IDX_W-1:0]  next_base;
  logic [cpl_pkg::IDX_W-1:0]  base_a [cpl_pkg::NUM_OFF];
  logic [cpl_pkg::CELL_W-1:0] s_a [cpl_pkg::NUM_OFF];

  // clamp oversized grid
  assign dx = (cfg.cells_x > cpl_pkg::MAX_CELLS_PER_AXIS) ? cpl_pkg::MAX_CELLS_PER_AXIS
                                                          : cfg.cells_x;
  assign dy = (cfg.cells_y > cpl_pkg::MAX_CELLS_PER_AXIS) ? cpl_pkg::MAX_CELLS_PER_AXIS
                                                          : cfg.cells_y;

  assign in_grid = ({1'b0, cell_x} < dx) && ({1'b0, cell_y} < dy);
  assign x_last  = (({1'b0, cell_x} + 7'd1) == dx);
  assign y_last  = (({1'b0, cell_y} + 7'd1) == dy);
  assign y_first = (cell_y == '0);

  assign prod       = 13'(cell_x) * 13'(dy);
  assign row_base   = prod[cpl_pkg::IDX_W-1:0];
  assign next_base  = row_base + 12'(dy);
  assign home_index = row_base + 12'(cell_y);

  always_comb begin
    for (int k = 0; k < cpl_pkg::NUM_OFF; k++) begin
      if (cpl_pkg::OFF_L[k]) begin
        cand[k].shift_x = x_last ? 2'sd1 : 2'sd0;
        base_a[k]       = x_last ? '0 : next_base;
      end else begin
        cand[k].shift_x = 2'sd0;
        base_a[k]       = row_base;
      end
      if (cpl_pkg::OFF_M[k] == 2'sd1) begin
        cand[k].shift_y = y_last ? 2'sd1 : 2'sd0;
        s_a[k]          = y_last ? '0 : cell_y + 6'd1;
      end else if (cpl_pkg::OFF_M[k] == -2'sd1) begin
        cand[k].shift_y = y_first ? -2'sd1 : 2'sd0;
        s_a[k]          = y_first ? 6'(dy - 7'd1) : cell_y - 6'd1;
      end else begin
        cand[k].shift_y = 2'sd0;
        s_a[k]          = cell_y;
      end
      cand[k].neighbour_index = base_a[k] + 12'(s_a[k]);
      keep[k] = in_grid && (cfg.periodic_x || (cand[k].shift_x == 2'sd0))
                        && (cfg.periodic_y || (cand[k].shift_y == 2'sd0));
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import cpl_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  home;
    logic [IDX_W-1:0]  nbr;
    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } cell_pair_t;

  typedef struct {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic              nl;
  } cell_req_t;

  localparam int STEP_X [NUM_OFF] = '{0, 0, 1, 1, 1};
  localparam int STEP_Y [NUM_OFF] = '{0, 1, -1, 0, 1};
  localparam int HOLD_LEN = 300;
  localparam int FULL_CELLS = 13;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  cpl_in_if  in_ch ();
  cpl_out_if out_ch ();

  cell_pair_list_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // grid model and pair list state
  cfg_t grid_cfg = '{cells_x: 7'd1, cells_y: 7'd1, periodic_x: 1'b1, periodic_y: 1'b1};
  logic [SLOT_W-1:0] slot_ctr = '0;
  cell_pair_t expected_pairs [$];
  cell_req_t  pending_cells [$];

  int errors = 0;
  int cells_taken = 0;
  int pairs_seen = 0;
  int slot_wraps = 0;
  int settings_used = 0;
  bit in_taken = 1'b0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  bit rx_hold = 1'b0;
  int hold_cnt = 0;
  int stim_dx = 1;
  int stim_dy = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_cells(logic [DIM_W-1:0] v);
    return (v > MAX_CELLS_PER_AXIS) ? int'(MAX_CELLS_PER_AXIS) : int'(v);
  endfunction

  task automatic add_cell_pairs(cell_req_t c);
    int dx, dy, cx, cy, r, s, sx, sy;
    cell_pair_t p;
    cell_pair_t kept [$];
    dx = eff_cells(grid_cfg.cells_x);
    dy = eff_cells(grid_cfg.cells_y);
    cx = int'(c.x);
    cy = int'(c.y);
    if (c.nl) slot_ctr = '0;
    if (cx >= dx || cy >= dy) return;
    for (int k = 0; k < NUM_OFF; k++) begin
      r = cx + STEP_X[k];
      s = cy + STEP_Y[k];
      sx = (r < 0) ? -1 : ((r > dx - 1) ? 1 : 0);
      sy = (s < 0) ? -1 : ((s > dy - 1) ? 1 : 0);
      if (r < 0) r = dx - 1;
      else if (r > dx - 1) r = 0;
      if (s < 0) s = dy - 1;
      else if (s > dy - 1) s = 0;
      if (!grid_cfg.periodic_x && sx != 0) continue;
      if (!grid_cfg.periodic_y && sy != 0) continue;
      p.home = IDX_W'(cx * dy + cy);
      p.nbr  = IDX_W'(r * dy + s);
      p.sx   = 2'(sx);
      p.sy   = 2'(sy);
      p.slot = slot_ctr;
      p.last = 1'b0;
      kept.push_back(p);
      slot_ctr = slot_ctr + 1'b1;
      if (slot_ctr == '0) slot_wraps++;
    end
    if (kept.size() != 0) kept[$].last = 1'b1;
    foreach (kept[n]) expected_pairs.push_back(kept[n]);
  endtask

  // monitor: config, result check, input prediction
  always @(posedge clk) begin
    cell_pair_t e;
    cell_req_t c;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CELLS_X:    grid_cfg.cells_x = cfg_data;
          REG_CELLS_Y:    grid_cfg.cells_y = cfg_data;
          REG_PERIODIC_X: grid_cfg.periodic_x = cfg_data[0];
          REG_PERIODIC_Y: grid_cfg.periodic_y = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        pairs_seen++;
        if (expected_pairs.size() == 0) begin
          errors++;
          $display("%0t unexpected pair beat: home %0d nbr %0d slot %0d", $time,
                   out_ch.home_index, out_ch.neighbour_index, out_ch.slot);
        end else begin
          e = expected_pairs.pop_front();
          if (out_ch.home_index !== e.home || out_ch.neighbour_index !== e.nbr ||
              out_ch.shift_x !== e.sx || out_ch.shift_y !== e.sy ||
              out_ch.slot !== e.slot || out_ch.last !== e.last) begin
            errors++;
            $display("%0t mismatch: expected home %0d nbr %0d sh %0d/%0d slot %0d last %0b",
                     $time, e.home, e.nbr, e.sx, e.sy, e.slot, e.last);
            $display("%0t   actual home %0d nbr %0d sh %0d/%0d slot %0d last %0b",
                     $time, out_ch.home_index, out_ch.neighbour_index, out_ch.shift_x,
                     out_ch.shift_y, out_ch.slot, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        cells_taken++;
        c.x = in_ch.cell_x;
        c.y = in_ch.cell_y;
        c.nl = in_ch.new_list;
        add_cell_pairs(c);
      end
    end
  end

  // cell driver
  always @(negedge clk) begin
    cell_req_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_cells.size() != 0 &&
          !(send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct)) begin
        c = pending_cells.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.cell_x   <= c.x;
        in_ch.cell_y   <= c.y;
        in_ch.new_list <= c.nl;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // pair receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt = 0;
    end else if (rx_hold) begin
      if (hold_cnt < HOLD_LEN) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else begin
      hold_cnt = 0;
      out_ch.ready <= !(stall_pct > 0 && $urandom_range(1, 100) <= stall_pct);
    end
  end

  task automatic push_cell(int x, int y, bit nl);
    cell_req_t c;
    c.x = CELL_W'(x);
    c.y = CELL_W'(y);
    c.nl = nl;
    pending_cells.push_back(c);
  endtask

  task automatic push_random(int n, int nl_pct);
    int x, y;
    repeat (n) begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
      if (stim_dx > 0 && stim_dy > 0 && $urandom_range(1, 100) <= 88) begin
        x = $urandom_range(0, stim_dx - 1);
        y = $urandom_range(0, stim_dy - 1);
      end
      push_cell(x, y, $urandom_range(1, 100) <= nl_pct);
    end
  endtask

  task automatic wait_drained(int extra);
    while (pending_cells.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(int cx, int cy, bit px, bit py);
    wait_drained(8);
    write_reg(REG_CELLS_X, DIM_W'(cx));
    write_reg(REG_CELLS_Y, DIM_W'(cy));
    write_reg(REG_PERIODIC_X, {6'($urandom_range(0, 63)), px});
    write_reg(REG_PERIODIC_Y, {6'($urandom_range(0, 63)), py});
    stim_dx = eff_cells(DIM_W'(cx));
    stim_dy = eff_cells(DIM_W'(cy));
    settings_used++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 50; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 50; end
      default: begin send_gap_pct = 22; stall_pct = 22; end
    endcase
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.new_list = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset grid is 1 x 1, periodic
    push_cell(0, 0, 0);
    push_cell(0, 0, 0);
    push_cell(1, 0, 0);
    push_cell(0, 1, 0);
    push_cell(63, 63, 1);
    push_cell(0, 0, 0);
    set_grid(64, 64, 1, 1);
    push_cell(0, 0, 1);
    push_cell(63, 63, 0);
    push_cell(0, 63, 0);
    push_cell(63, 0, 0);
    push_cell(31, 32, 0);
    set_grid(64, 64, 0, 0);
    push_cell(0, 0, 0);
    push_cell(63, 63, 0);
    push_cell(0, 63, 0);
    push_cell(63, 0, 0);
    set_grid(0, 5, 1, 1);
    push_cell(0, 0, 1);
    set_grid(127, 127, 0, 1);
    push_cell(63, 63, 0);
    push_cell(63, 0, 0);
    set_grid(3, 1, 1, 0);
    push_cell(2, 0, 0);
    push_cell(0, 0, 0);

    // short run with full pairs on a periodic grid
    set_grid(64, 64, 1, 1);
    push_cell(5, 5, 1);
    push_random(FULL_CELLS, 0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_grid(64, 64, 1, 1);
        1: set_grid(64, 64, 0, 0);
        2: set_grid(1, 1, 0, 0);
        3: set_grid($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 1),
                    $urandom_range(0, 1));
        4: set_grid(127, 5, 1, 0);
        5: set_grid(0, $urandom_range(0, 127), 1, 1);
        6: set_grid($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 1),
                    $urandom_range(0, 1));
        default: set_grid(2, 64, 0, 1);
      endcase
      set_idle(p % 4);
      if (p == 5) begin
        push_random(10, 5);
      end else begin
        push_random(24, 5);
        if (p == 1) wait_drained(0);
        if (p == 3) begin
          rx_hold = 1'b1;
          push_random(30, 0);
          wait (hold_cnt >= HOLD_LEN);
          rx_hold = 1'b0;
        end
        // stretch without any idling inside the phase
        if (p == 6) begin
          wait (pending_cells.size() == 0);
          set_idle(0);
        end
        push_random(24, 5);
      end
    end

    set_idle(0);
    wait_drained(20);
    if (expected_pairs.size() != 0) begin
      errors++;
      $display("%0t %0d expected pairs never arrived", $time, expected_pairs.size());
    end
    $display("covered %0d cells over %0d grid settings, %0d pair beats checked",
             cells_taken, settings_used, pairs_seen);
    $display("slot counter wrapped %0d time(s), %0d error(s)", slot_wraps, errors);
    if (errors == 0) begin
      $display("[cell_pair_list_generator] OK");
    end else begin
      $display("[cell_pair_list_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout at %0t", $time);
    $display("[cell_pair_list_generator] ERROR");
    $finish;
  end

endmodule
